FILE: rtl/battery_meter_display_encoder_core_macros.svh
// Assertion macros shared by the battery meter display encoder RTL.
`ifndef BATTERY_METER_DISPLAY_ENCODER_CORE_MACROS_SVH
`define BATTERY_METER_DISPLAY_ENCODER_CORE_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define BMDE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define BMDE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/bmde_pkg.sv
// Package: constants, result type and digit helpers for the battery meter encoder.
`timescale 1ns / 1ps
package bmde_pkg;

	localparam logic [14:0] VoltBaseMv = 15'd3000;
	localparam logic [14:0] VoltFullMv = 15'd3800;
	localparam logic [14:0] VoltSatMv  = 15'd9994;
	localparam logic [13:0] RoundMv    = 14'd5;

	localparam logic [2:0] UnitVolts   = 3'b011;
	localparam logic [2:0] UnitPercent = 3'b100;

	localparam logic [3:0] BlankIdx = 4'd10;

	localparam logic [4:0] BarsNone  = 5'b00000;
	localparam logic [4:0] BarsOne   = 5'b10000;
	localparam logic [4:0] BarsTwo   = 5'b11000;
	localparam logic [4:0] BarsThree = 5'b11100;
	localparam logic [4:0] BarsFour  = 5'b11110;
	localparam logic [4:0] BarsFull  = 5'b11111;

	localparam int WordW = 29;

	typedef struct packed {
		logic [WordW-1:0] word;
		logic             error;
	} result_t;

	typedef struct packed {
		logic [3:0]  digit;
		logic [13:0] rem;
	} digit_t;

	// Segment pattern for a digit index; the blank code lights nothing.
	function automatic logic [6:0] seg7(input logic [3:0] idx);
		logic [6:0] seg;
		case (idx)
			4'd0:     seg = 7'b0111111;
			4'd1:     seg = 7'b0000011;
			4'd2:     seg = 7'b1101101;
			4'd3:     seg = 7'b1100111;
			4'd4:     seg = 7'b1010011;
			4'd5:     seg = 7'b1110110;
			4'd6:     seg = 7'b1111110;
			4'd7:     seg = 7'b0100011;
			4'd8:     seg = 7'b1111111;
			4'd9:     seg = 7'b1110111;
			default:  seg = 7'b0000000;
		endcase
		return seg;
	endfunction

	// Peel one decimal digit off val at the given weight; val must be below ten weights.
	function automatic digit_t digit_step(input logic [13:0] val, input logic [13:0] weight);
		digit_t     res;
		logic [13:0] thr;
		res.digit = 4'd0;
		res.rem   = val;
		thr       = weight;
		for (int k = 1; k < 10; k++) begin
			if (val >= thr) begin
				res.digit = 4'(k);
				res.rem   = val - thr;
			end
			thr = thr + weight;
		end
		return res;
	endfunction

endpackage

FILE: rtl/bmde_encode.sv
// Combinational conversion of one reading into the display word and error flag.
`timescale 1ns / 1ps
module bmde_encode (
	input  logic [15:0]      millivolts,
	input  logic [7:0]       status_bits,
	output bmde_pkg::result_t result
);
	import bmde_pkg::*;

	logic        neg;
	logic [14:0] mv;
	logic [14:0] diff;
	logic [6:0]  pct;
	logic [4:0]  bars;
	logic [13:0] vsat;
	logic [13:0] vround;
	digit_t      dig_th;
	digit_t      dig_hu;
	digit_t      dig_te;
	digit_t      dig_pct;
	logic [3:0]  idx_l;
	logic [3:0]  idx_m;
	logic [3:0]  idx_r;
	logic [2:0]  unit;

	assign neg  = millivolts[15];
	assign mv   = millivolts[14:0];
	assign diff = mv - VoltBaseMv;

	always_comb begin
		if (mv > VoltFullMv) begin
			pct = 7'd100;
		end else if (mv < VoltBaseMv) begin
			pct = 7'd0;
		end else begin
			pct = diff[9:3];
		end
	end

	always_comb begin
		if (pct < 7'd5) begin
			bars = BarsNone;
		end else if (pct < 7'd30) begin
			bars = BarsOne;
		end else if (pct < 7'd50) begin
			bars = BarsTwo;
		end else if (pct < 7'd70) begin
			bars = BarsThree;
		end else if (pct <= 7'd90) begin
			bars = BarsFour;
		end else begin
			bars = BarsFull;
		end
	end

	// Hundredths digits are the upper three decimal digits of the rounded reading.
	assign vsat    = (mv > VoltSatMv) ? VoltSatMv[13:0] : mv[13:0];
	assign vround  = vsat + RoundMv;
	assign dig_th  = digit_step(vround, 14'd1000);
	assign dig_hu  = digit_step(dig_th.rem, 14'd100);
	assign dig_te  = digit_step(dig_hu.rem, 14'd10);
	assign dig_pct = digit_step({7'd0, pct}, 14'd10);

	always_comb begin
		if (status_bits[0] == 1'b0) begin
			unit  = UnitVolts;
			idx_l = dig_th.digit;
			idx_m = dig_hu.digit;
			idx_r = dig_te.digit;
		end else if (pct >= 7'd100) begin
			unit  = UnitPercent;
			idx_l = 4'd1;
			idx_m = 4'd0;
			idx_r = 4'd0;
		end else if (pct >= 7'd10) begin
			unit  = UnitPercent;
			idx_l = BlankIdx;
			idx_m = dig_pct.digit;
			idx_r = dig_pct.rem[3:0];
		end else begin
			unit  = UnitPercent;
			idx_l = BlankIdx;
			idx_m = BlankIdx;
			idx_r = pct[3:0];
		end
	end

	always_comb begin
		result.error = neg;
		if (neg) begin
			result.word = '0;
		end else begin
			result.word = {bars, unit, seg7(idx_l), seg7(idx_m), seg7(idx_r)};
		end
	end

endmodule

FILE: rtl/battery_meter_display_encoder_core.sv
// Top level of the battery meter display encoder: input register, encoder, result register.
// An accepted request passes the input stage and then the result stage before its result is valid.
// Throughput: one request per cycle while out_ready holds; the encoder between the stages sets the clock path.
// Reset: arst_n clears both stage valid flags asynchronously; payload registers are not reset.
`timescale 1ns / 1ps
`include "battery_meter_display_encoder_core_macros.svh"
module battery_meter_display_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [15:0] millivolts,
	input  logic [7:0]  status_bits,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [28:0] display_word,
	output logic        error
);
	import bmde_pkg::*;

	// Input stage holds the raw request.
	logic        valid_s1;
	logic [15:0] millivolts_s1;
	logic [7:0]  status_s1;

	// Result stage holds the encoded word until the consumer takes it.
	logic        valid_s2;
	result_t     result_s2;

	result_t     result_enc;
	logic        ready_s2;

	// Each stage advances when the one after it is empty or draining this cycle.
	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Capture payload only on a transfer; hold it otherwise.
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			millivolts_s1 <= millivolts;
			status_s1     <= status_bits;
		end
		if (ready_s2 && valid_s1) begin
			result_s2 <= result_enc;
		end
	end

	bmde_encode u_encode (
		.millivolts  (millivolts_s1),
		.status_bits (status_s1),
		.result      (result_enc)
	);

	assign out_valid    = valid_s2;
	assign display_word = result_s2.word;
	assign error        = result_s2.error;

	// An accepted request always lands in the input stage.
	`BMDE_ASSERT_NEXT(a_in_lands, in_valid && in_ready, valid_s1)
	// A request moving into the result stage carries its sign through as the error flag.
	`BMDE_ASSERT_NEXT(a_err_follows, valid_s1 && ready_s2, error == $past(millivolts_s1[15]))
	// An error result never shows a display word.
	`BMDE_ASSERT_NOW(a_err_blank, out_valid && error, display_word == '0)
	// A good result always names one of the two units.
	`BMDE_ASSERT_NOW(a_unit_ok, out_valid && !error, display_word[23:21] == UnitVolts || display_word[23:21] == UnitPercent)

endmodule

FILE: verif/tb_top.sv
// Testbench for battery_meter_display_encoder_core: directed and random readings checked against a local encoder.
`timescale 1ns / 1ps
module tb_top;
	import bmde_pkg::*;

	// Segment glyphs packed side by side, index 0 in the low bits, blank in the top slot.
	localparam logic [76:0] GlyphRom = {
		7'b0000000, 7'b1110111, 7'b1111111, 7'b0100011, 7'b1111110, 7'b1110110,
		7'b1010011, 7'b1100111, 7'b1101101, 7'b0000011, 7'b0111111
	};
	localparam int IdlePct = 36;
	localparam int RandomReadings = 750;
	localparam int DrainCycles = 8;

	typedef struct {
		logic [15:0] mv;
		logic [7:0]  st;
		bit          typed;
		result_t     want;
	} probe_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [15:0] millivolts;
	logic [7:0]  status_bits;
	logic        out_valid;
	logic        out_ready;
	logic [28:0] display_word;
	logic        error;

	result_t pending_readouts[$];
	probe_t  probe_rows[$];
	int      err_count = 0;
	bit      steady = 0;

	battery_meter_display_encoder_core uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.millivolts   (millivolts),
		.status_bits  (status_bits),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.display_word (display_word),
		.error        (error)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Look up the segment pattern for a digit index; anything past nine is blank.
	function automatic logic [6:0] glyph(input logic [3:0] idx);
		int slot;
		slot = (idx > 4'd10) ? 10 : int'(idx);
		return GlyphRom[slot*7 +: 7];
	endfunction

	// Compute the display word and error flag the encoder must produce for one reading.
	function automatic result_t encode_reading(input logic [15:0] raw, input logic [7:0] st);
		result_t     r;
		int unsigned mv;
		int unsigned pct;
		int unsigned v;
		int unsigned hund;
		logic [4:0]  bars;
		logic [2:0]  unit;
		logic [3:0]  d_left;
		logic [3:0]  d_mid;
		logic [3:0]  d_right;
		r = '0;
		if (raw[15]) begin
			// Sensor fault: flag it and leave the display word clear.
			r.error = 1'b1;
			return r;
		end
		mv = 32'(raw);
		if (mv > VoltFullMv)
			pct = 100;
		else if (mv < VoltBaseMv)
			pct = 0;
		else
			pct = (mv - VoltBaseMv) / 8;

		if (pct < 5)
			bars = BarsNone;
		else if (pct < 30)
			bars = BarsOne;
		else if (pct < 50)
			bars = BarsTwo;
		else if (pct < 70)
			bars = BarsThree;
		else if (pct <= 90)
			bars = BarsFour;
		else
			bars = BarsFull;

		if (!st[0]) begin
			// Volts: clamp, round half up to hundredths, carry ripples freely.
			unit = UnitVolts;
			v = (mv > VoltSatMv) ? int'(VoltSatMv) : mv;
			hund = (v + RoundMv) / 10;
			d_left = 4'(hund / 100);
			d_mid = 4'((hund / 10) % 10);
			d_right = 4'(hund % 10);
		end else begin
			// Percent: blank the leading digits that carry no weight.
			unit = UnitPercent;
			if (pct >= 100) begin
				d_left = 4'd1;
				d_mid = 4'd0;
				d_right = 4'd0;
			end else if (pct >= 10) begin
				d_left = BlankIdx;
				d_mid = 4'(pct / 10);
				d_right = 4'(pct % 10);
			end else begin
				d_left = BlankIdx;
				d_mid = BlankIdx;
				d_right = 4'(pct);
			end
		end
		r.word = {bars, unit, glyph(d_left), glyph(d_mid), glyph(d_right)};
		return r;
	endfunction

	// Print one mismatch line and count it.
	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
		err_count++;
	endtask

	task automatic add_probe(input logic [15:0] mv, input logic [7:0] st, input bit typed,
			input result_t want);
		probe_t p;
		p.mv = mv;
		p.st = st;
		p.typed = typed;
		p.want = want;
		probe_rows.push_back(p);
	endtask

	// Offer one request after a random idle gap; return at the edge that takes it.
	task automatic send_request(input logic [15:0] mv, input logic [7:0] st);
		// Hold valid low for a random gap unless the steady stretch is on.
		while (!steady && $urandom_range(0, 99) < IdlePct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		millivolts <= mv;
		status_bits <= st;
		// Hold the payload until the block takes it.
		forever begin
			@(posedge clk);
			if (in_ready)
				break;
		end
	endtask

	// Drive the result side: stall at random, never during the steady stretch.
	always @(negedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= steady || ($urandom_range(0, 99) >= IdlePct);
	end

	// Compare every result taken against the oldest pending readout.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_readouts.size() == 0) begin
				report_mismatch("unexpected result", {3'b0, display_word}, 32'h0);
			end else begin
				want = pending_readouts.pop_front();
				if (display_word !== want.word)
					report_mismatch("display_word", {3'b0, display_word}, {3'b0, want.word});
				if (error !== want.error)
					report_mismatch("error", {31'b0, error}, {31'b0, want.error});
			end
		end
	end

	initial begin
		logic [15:0] mv;
		logic [7:0]  st;
		int          pick;
		result_t     none;

		arst_n = 1'b0;
		in_valid = 1'b0;
		millivolts = '0;
		status_bits = '0;
		out_ready = 1'b0;
		none = '0;

		// Readings whose display can be read off directly.
		add_probe(16'h8000, 8'h00, 1, '{word: '0, error: 1'b1});
		add_probe(16'hFFFF, 8'hFF, 1, '{word: '0, error: 1'b1});
		add_probe(16'h7FFF, 8'h00, 1, '{word: {BarsFull, UnitVolts,
				7'b1110111, 7'b1110111, 7'b1110111}, error: 1'b0});
		add_probe(16'h7FFF, 8'h01, 1, '{word: {BarsFull, UnitPercent,
				7'b0000011, 7'b0111111, 7'b0111111}, error: 1'b0});
		add_probe(16'h0000, 8'h00, 1, '{word: {BarsNone, UnitVolts,
				7'b0111111, 7'b0111111, 7'b0111111}, error: 1'b0});
		add_probe(16'h0000, 8'h01, 1, '{word: {BarsNone, UnitPercent,
				7'b0000000, 7'b0000000, 7'b0111111}, error: 1'b0});
		// Percent and bar boundaries, both display modes.
		add_probe(16'd2999, 8'h01, 0, none);
		add_probe(16'd3000, 8'h00, 0, none);
		add_probe(16'd3039, 8'h01, 0, none);
		add_probe(16'd3040, 8'hFE, 0, none);
		add_probe(16'd3080, 8'h01, 0, none);
		add_probe(16'd3240, 8'h03, 0, none);
		add_probe(16'd3400, 8'h01, 0, none);
		add_probe(16'd3560, 8'h81, 0, none);
		add_probe(16'd3727, 8'h01, 0, none);
		add_probe(16'd3728, 8'h01, 0, none);
		add_probe(16'd3800, 8'h01, 0, none);
		add_probe(16'd3801, 8'h01, 0, none);
		// Rounding carry through tenths into units, and the saturation edge.
		add_probe(16'd1995, 8'h00, 0, none);
		add_probe(16'd4995, 8'hAA, 0, none);
		add_probe(16'd9985, 8'h00, 0, none);
		add_probe(16'd9994, 8'h00, 0, none);
		add_probe(16'd9995, 8'h00, 0, none);
		add_probe(16'd4, 8'h00, 0, none);

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		foreach (probe_rows[i]) begin
			send_request(probe_rows[i].mv, probe_rows[i].st);
			pending_readouts.push_back(probe_rows[i].typed ? probe_rows[i].want :
					encode_reading(probe_rows[i].mv, probe_rows[i].st));
		end

		// Random readings, mostly around the charge window where bars and percent move.
		for (int n = 0; n < RandomReadings; n++) begin
			steady = (n >= 300 && n < 450);
			pick = $urandom_range(0, 99);
			if (pick < 55)
				mv = 16'($urandom_range(2950, 3850));
			else if (pick < 70)
				mv = 16'($urandom_range(0, 10100));
			else if (pick < 80)
				mv = 16'h8000 | 16'($urandom_range(0, 32767));
			else
				mv = 16'($urandom());
			st = 8'($urandom());
			send_request(mv, st);
			pending_readouts.push_back(encode_reading(mv, st));
		end
		steady = 0;

		@(negedge clk);
		in_valid <= 1'b0;

		// Drain: wait for every pending readout, then watch DrainCycles more clock edges for strays.
		wait (pending_readouts.size() == 0);
		repeat (DrainCycles) @(posedge clk);

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Stop a hung run.
	initial begin
		#4000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bmde_pkg.sv
rtl/bmde_encode.sv
rtl/battery_meter_display_encoder_core.sv
verif/tb_top.sv
